/* hdl/cep_pkg.sv */
// Types shared by the cable endpoint position pipeline cells and top level.
// No dependencies.
`default_nettype none
package cep_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned LenW  = 24;
   localparam int unsigned NumW  = WordW + LenW;
   localparam int unsigned RadW  = 2 * WordW;
   localparam int unsigned RemW  = WordW + 2;
   localparam int unsigned SqrtSteps = WordW;
   localparam int unsigned DivSteps  = LenW;

   localparam logic [2:0] CSR_LEN = 3'd0;
   localparam logic [LenW-1:0] LEN_RESET = 24'd131072;

   // side data that travels with a word through the chain
   typedef struct packed {
      logic                        zero;
      logic [2:0]                  sgn;
      logic [2:0][WordW-1:0]       load;
      logic [2:0][NumW-1:0]        num;
   } ctx_type;

   typedef struct packed {
      ctx_type                     ctx;
      logic [RadW-1:0]             rad;
      logic [RemW-1:0]             rem;
      logic [WordW-1:0]            root;
   } sqrt_type;

   typedef struct packed {
      ctx_type                     ctx;
      logic [WordW-1:0]            den;
      logic [2:0][WordW-1:0]       rem;
      logic [2:0][LenW-1:0]        quo;
   } div_type;

endpackage
`default_nettype wire

/* hdl/cep_sqrt_cell.sv */
// One step of the integer square root: two radicand bits in, one root bit out.
// Depends on cep_pkg.
`default_nettype none
module cep_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire cep_pkg::sqrt_type in_word,
   output logic                   out_valid,
   output cep_pkg::sqrt_type      out_word
);

   logic                  valid_ff;
   cep_pkg::sqrt_type     word_ff;
   cep_pkg::sqrt_type     word_in;
   logic [cep_pkg::RemW-1:0] part;
   logic [cep_pkg::RemW-1:0] trial;

   always_comb begin
      part  = {in_word.rem[cep_pkg::RemW-3:0], in_word.rad[cep_pkg::RadW-1 -: 2]};
      trial = {in_word.root, 2'b01};
      word_in     = in_word;
      word_in.rad = {in_word.rad[cep_pkg::RadW-3:0], 2'b00};
      if (part >= trial) begin
         word_in.rem  = part - trial;
         word_in.root = {in_word.root[cep_pkg::WordW-2:0], 1'b1};
      end else begin
         word_in.rem  = part;
         word_in.root = {in_word.root[cep_pkg::WordW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

/* hdl/cep_div_cell.sv */
// One restoring division step for all three components, one quotient bit each.
// Depends on cep_pkg.
`default_nettype none
module cep_div_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire cep_pkg::div_type in_word,
   output logic                  out_valid,
   output cep_pkg::div_type      out_word
);

   logic                 valid_ff;
   cep_pkg::div_type     word_ff;
   cep_pkg::div_type     word_in;
   logic [cep_pkg::WordW:0] part;

   always_comb begin
      word_in = in_word;
      part    = '0;
      for (int i = 0; i < 3; i++) begin
         part = {in_word.rem[i], in_word.ctx.num[i][cep_pkg::LenW-1]};
         word_in.ctx.num[i] = {in_word.ctx.num[i][cep_pkg::NumW-2:0], 1'b0};
         if (part >= {1'b0, in_word.den}) begin
            word_in.rem[i] = cep_pkg::WordW'(part - {1'b0, in_word.den});
            word_in.quo[i] = {in_word.quo[i][cep_pkg::LenW-2:0], 1'b1};
         end else begin
            word_in.rem[i] = part[cep_pkg::WordW-1:0];
            word_in.quo[i] = {in_word.quo[i][cep_pkg::LenW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

/* hdl/cable_endpoint_position_core.sv */
// Cable endpoint position: force normalised, scaled by cable length, added to load in x
// and subtracted from it in y and z. Depends on cep_pkg, cep_sqrt_cell and cep_div_cell.
//
// Input words arrive on req_valid / req_stall with three force and three load
// components (signed Q16.16). Each word gives one result on rsp_valid /
// rsp_stall: pos_x, pos_y, pos_z (saturated Q16.16) and zero_force.
// The pipeline has one multiply stage, one sum stage, 32 square root cells,
// 24 divider cells and the output register. A new word may enter every cycle
// while req_stall is low; the whole row of cells moves together.
// When the output word is held by rsp_stall the row freezes and req_stall
// rises in the same cycle; it falls as soon as the output is taken.
// The cable length is written through the APB port at address 0 (Q8.16, reset
// value 2.0 m); write it only while the pipeline is empty.
// Synchronous reset empties the pipeline and restores the cable length.
`default_nettype none
module cable_endpoint_position_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_force_x,
   input  wire logic signed [31:0] req_force_y,
   input  wire logic signed [31:0] req_force_z,
   input  wire logic signed [31:0] req_load_x,
   input  wire logic signed [31:0] req_load_y,
   input  wire logic signed [31:0] req_load_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic             rsp_zero_force,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned W = cep_pkg::WordW;

   logic                       adv;
   logic [cep_pkg::LenW-1:0]   len_ff;

   // configuration
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= cep_pkg::LEN_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == cep_pkg::CSR_LEN[2])) begin
         len_ff <= pwdata[cep_pkg::LenW-1:0];
      end
   end
   assign prdata = (paddr[2] == cep_pkg::CSR_LEN[2]) ?
                   {{(32-cep_pkg::LenW){1'b0}}, len_ff} : '0;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: magnitudes, squares and numerators
   logic [2:0][W-1:0]          force_w;
   logic [2:0][W-1:0]          mag;
   logic                       s1_valid_ff;
   logic [2:0][cep_pkg::RadW-1:0] s1_sq_ff;
   cep_pkg::ctx_type           s1_ctx_ff;
   cep_pkg::ctx_type           s1_ctx_in;

   always_comb begin
      force_w = {req_force_z, req_force_y, req_force_x};
      s1_ctx_in.zero = (force_w == '0);
      s1_ctx_in.load = {req_load_z, req_load_y, req_load_x};
      for (int i = 0; i < 3; i++) begin
         s1_ctx_in.sgn[i] = force_w[i][W-1];
         mag[i] = force_w[i][W-1] ? (~force_w[i] + 1'b1) : force_w[i];
         s1_ctx_in.num[i] = cep_pkg::NumW'(mag[i]) * cep_pkg::NumW'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff <= s1_ctx_in;
         for (int i = 0; i < 3; i++) begin
            s1_sq_ff[i] <= cep_pkg::RadW'(mag[i]) * cep_pkg::RadW'(mag[i]);
         end
      end
   end

   // stage 2: sum of squares
   logic              s2_valid_ff;
   cep_pkg::sqrt_type s2_word_ff;
   cep_pkg::sqrt_type s2_word_in;

   always_comb begin
      s2_word_in.ctx  = s1_ctx_ff;
      s2_word_in.rad  = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      s2_word_in.rem  = '0;
      s2_word_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_word_ff <= s2_word_in;
      end
   end

   // square root row
   logic              sq_valid [cep_pkg::SqrtSteps+1];
   cep_pkg::sqrt_type sq_word  [cep_pkg::SqrtSteps+1];

   assign sq_valid[0] = s2_valid_ff;
   assign sq_word[0]  = s2_word_ff;

   for (genvar k = 0; k < cep_pkg::SqrtSteps; k++) begin : g_sqrt
      cep_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[k]),
         .in_word   (sq_word[k]),
         .out_valid (sq_valid[k+1]),
         .out_word  (sq_word[k+1])
      );
   end

   // divider row
   logic             dv_valid [cep_pkg::DivSteps+1];
   cep_pkg::div_type dv_word  [cep_pkg::DivSteps+1];
   cep_pkg::div_type dv_first;

   always_comb begin
      dv_first.ctx = sq_word[cep_pkg::SqrtSteps].ctx;
      dv_first.den = sq_word[cep_pkg::SqrtSteps].root;
      for (int i = 0; i < 3; i++) begin
         dv_first.rem[i] = sq_word[cep_pkg::SqrtSteps].ctx.num[i][cep_pkg::NumW-1 -: W];
         dv_first.quo[i] = '0;
      end
   end

   assign dv_valid[0] = sq_valid[cep_pkg::SqrtSteps];
   assign dv_word[0]  = dv_first;

   for (genvar k = 0; k < cep_pkg::DivSteps; k++) begin : g_div
      cep_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[k]),
         .in_word   (dv_word[k]),
         .out_valid (dv_valid[k+1]),
         .out_word  (dv_word[k+1])
      );
   end

   // output register
   function automatic logic [W-1:0] sat_add(input logic [W-1:0] load, input logic neg,
                                            input logic [cep_pkg::LenW-1:0] q);
      logic signed [W+1:0] off;
      logic signed [W+1:0] sum;
      off = neg ? -$signed({{(W+2-cep_pkg::LenW){1'b0}}, q})
                :  $signed({{(W+2-cep_pkg::LenW){1'b0}}, q});
      sum = $signed({{2{load[W-1]}}, load}) + off;
      if (sum > $signed({3'b000, {(W-1){1'b1}}})) begin
         sat_add = {1'b0, {(W-1){1'b1}}};
      end else if (sum < $signed({3'b111, {(W-1){1'b0}}})) begin
         sat_add = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_add = sum[W-1:0];
      end
   endfunction

   cep_pkg::div_type   last;
   logic               rsp_valid_ff;
   logic [2:0][W-1:0]  pos_ff;
   logic [2:0][W-1:0]  pos_in;
   logic               zero_ff;

   always_comb begin
      last = dv_word[cep_pkg::DivSteps];
      if (last.ctx.zero) begin
         pos_in = last.ctx.load;
      end else begin
         pos_in[0] = sat_add(last.ctx.load[0],  last.ctx.sgn[0], last.quo[0]);
         pos_in[1] = sat_add(last.ctx.load[1], !last.ctx.sgn[1], last.quo[1]);
         pos_in[2] = sat_add(last.ctx.load[2], !last.ctx.sgn[2], last.quo[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[cep_pkg::DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff  <= pos_in;
         zero_ff <= last.ctx.zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = $signed(pos_ff[0]);
   assign rsp_pos_y      = $signed(pos_ff[1]);
   assign rsp_pos_z      = $signed(pos_ff[2]);
   assign rsp_zero_force = zero_ff;

`ifndef SYNTH
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      sq_valid[cep_pkg::SqrtSteps] && !sq_word[cep_pkg::SqrtSteps].ctx.zero
      |-> sq_word[cep_pkg::SqrtSteps].root != '0)
      else $error("square root zero for nonzero force");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      dv_valid[cep_pkg::DivSteps] && !last.ctx.zero
      |-> last.rem[0] < last.den && last.rem[1] < last.den && last.rem[2] < last.den)
      else $error("divider remainder out of range");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[2] == cep_pkg::CSR_LEN[2]
      |=> len_ff == $past(pwdata[cep_pkg::LenW-1:0]))
      else $error("cable length write lost");
`endif

endmodule
`default_nettype wire
